/* src/rpn_stack_calculator_defines.svh */
// Assertion macros for the RPN stack calculator
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpn assertion failed");
`define RPN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpn assertion failed");
`endif

/* src/rpn_pkg.sv */
// Types and constants for the RPN stack calculator
package rpn_pkg;
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;
  localparam logic [2:0] CMD_POP  = 3'd5;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_ZDIV  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_RDB, S_GOTB, S_RDA, S_GOTA, S_MUL, S_DIV, S_FIX, S_WB, S_OUT
  } state_t;
endpackage

/* src/rpn_stack_calculator.sv */
// RPN stack calculator: Q16.16 operand stack with push, arithmetic and pop
//
// Input channel: command, operand with in_valid/in_ready. Output channel:
// value, status, depth with out_valid/out_ready. Every item yields exactly
// one result item.
// One item is processed at a time; in_ready is high only when the block is
// idle and the output register is empty.
// Unused codes go straight to the output; push writes the operand to the
// stack; pop reads the top entry. Operators read b and a, then compute,
// saturate and write back; divide by zero or with an empty stack for the
// divisor skips to the output. Divide runs a radix-2 restoring loop of 48
// steps, one quotient bit per cycle. Taking the result frees the input in
// the next cycle. The stack RAM read latency sets the pop and operator
// cost; the divider loop sets the divide cost.
// Reset clears the stack pointer (stack empty) and drops any pending
// result. Stack RAM contents are not cleared; only written entries are read.
// When the receiver stalls, the result holds in the output register and
// no new item is accepted until it is taken.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic signed [31:0] operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic [2:0]         status,
  output logic [7:0]         depth
);
  import rpn_pkg::*;
  `include "rpn_stack_calculator_defines.svh"

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH);

  state_t state, state_next;
  logic [PW-1:0] sp, sp_next;
  logic [2:0] cmd;
  logic signed [31:0] opb, opa, res;
  logic signed [63:0] prod;
  logic empty, sat, neg;
  logic [63:0] rem;
  logic [31:0] dvs;
  logic [47:0] quo;
  logic [5:0] cnt;
  logic [2:0] st;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign raddr = AW'(sp - PW'(1));

  // combinational datapath helpers
  logic signed [32:0] addsub;
  logic signed [47:0] mq;
  logic [64:0] trial;
  logic [47:0] qmag;
  logic signed [48:0] qs;
  always_comb begin
    addsub = (cmd == CMD_ADD) ? ({opa[31], opa} + {opb[31], opb})
                              : ({opa[31], opa} - {opb[31], opb});
    mq = 48'(prod[63:16]);
    if (prod[63] && prod[15:0] != 16'd0) mq = mq + 48'sd1;
    trial = {1'b0, rem[62:0], quo[47]} - {33'd0, dvs};
    qmag = quo;
    qs = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_comb begin
    state_next = state;
    sp_next = sp;
    we = 1'b0;
    waddr = AW'(sp);
    wdata = res;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        priority if (command == CMD_PUSH) state_next = S_WB;
        else if (command == CMD_POP || (command >= CMD_ADD && command <= CMD_DIV))
          state_next = S_RDB;
        else state_next = S_OUT;
      end
      S_RDB: state_next = S_GOTB;
      S_GOTB: begin
        if (sp != '0) sp_next = sp - PW'(1);
        if (cmd == CMD_POP) state_next = S_OUT;
        else if (cmd == CMD_DIV && ((sp == '0) || rdata == 32'd0)) state_next = S_OUT;
        else state_next = S_RDA;
      end
      S_RDA: state_next = S_GOTA;
      S_GOTA: begin
        if (sp != '0) sp_next = sp - PW'(1);
        priority case (cmd)
          CMD_MUL: state_next = S_MUL;
          CMD_DIV: state_next = S_DIV;
          default: state_next = S_FIX;
        endcase
      end
      S_MUL: state_next = S_FIX;
      S_DIV: if (cnt == 6'd47) state_next = S_FIX;
      S_FIX: state_next = S_WB;
      S_WB: begin
        if (sp < FULL) begin
          we = 1'b1;
          sp_next = sp + PW'(1);
        end
        state_next = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sp <= sp_next;
      if (state == S_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        cmd <= command;
        res <= (command == CMD_PUSH) ? operand : 32'sd0;
        empty <= 1'b0;
        sat <= 1'b0;
        st <= ST_OK;
      end
      S_GOTB: begin
        opb <= (sp == '0) ? 32'sd0 : $signed(rdata);
        if (sp == '0) empty <= 1'b1;
        if (cmd == CMD_POP) res <= (sp == '0) ? 32'sd0 : $signed(rdata);
        if (cmd == CMD_DIV && ((sp == '0) || rdata == 32'd0)) begin
          res <= 32'sd0;
          st <= (sp == '0) ? ST_EMPTY : ST_ZDIV;
        end else if (cmd == CMD_POP && sp == '0) st <= ST_EMPTY;
      end
      S_GOTA: begin
        opa <= (sp == '0) ? 32'sd0 : $signed(rdata);
        if (sp == '0) empty <= 1'b1;
        neg <= ((sp == '0) ? 1'b0 : rdata[31]) ^ opb[31];
        rem <= '0;
        quo <= {(sp == '0) ? 32'd0 : (rdata[31] ? -rdata : rdata), 16'd0};
        dvs <= opb[31] ? 32'(-opb) : opb;
        cnt <= '0;
      end
      S_MUL: prod <= opa * opb;
      S_DIV: begin
        // restoring division of |a|<<16 by |b|, 48 quotient bits
        rem <= trial[64] ? {rem[62:0], quo[47]} : trial[63:0];
        quo <= {quo[46:0], ~trial[64]};
        cnt <= cnt + 6'd1;
      end
      S_FIX: begin
        priority case (cmd)
          CMD_MUL: begin
            if (mq > 48'sh7FFFFFFF) begin res <= 32'h7FFFFFFF; sat <= 1'b1; end
            else if (mq < -48'sh80000000) begin res <= 32'h80000000; sat <= 1'b1; end
            else res <= mq[31:0];
          end
          CMD_DIV: begin
            if (qs > 49'sh7FFFFFFF) begin res <= 32'h7FFFFFFF; sat <= 1'b1; end
            else if (qs < -49'sh80000000) begin res <= 32'h80000000; sat <= 1'b1; end
            else res <= qs[31:0];
          end
          default: begin
            if (addsub[32] != addsub[31]) begin
              res <= addsub[32] ? 32'h80000000 : 32'h7FFFFFFF;
              sat <= 1'b1;
            end else res <= addsub[31:0];
          end
        endcase
      end
      S_WB: begin
        if (cmd == CMD_PUSH) begin
          if (sp >= FULL) st <= ST_FULL;
          res <= 32'sd0;
        end else if (empty) st <= ST_EMPTY;
        else if (sat) st <= ST_SAT;
      end
      S_OUT: begin
        value <= res;
        status <= st;
        depth <= 8'(sp);
      end
      default: ;
    endcase
  end

  `RPN_ASSERT_IMPL(a_sp_range, 1'b1, sp <= FULL)
  `RPN_ASSERT_IMPL(a_ready_busy, in_ready, state == S_IDLE && !out_valid)
  `RPN_ASSERT_NEXT(a_out_set, state == S_OUT, out_valid)
endmodule

/* src/rpn_ram.sv */
// Generic single-port-write RAM with registered read
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
